[rtl/core/bdpc_pkg.sv]
// bdpc_pkg: shared types and constants of the button debounce and press classifier
// holds event codes, register indexes, register reset values and the config port widths
// no dependencies
`timescale 1ns / 1ps

package bdpc_pkg;

  // setting and config port widths
  localparam int SETTING_W  = 16;
  localparam int REG_IDX_W  = 4;
  localparam int CFG_DATA_W = SETTING_W;

  typedef logic [SETTING_W-1:0] setting_t;
  typedef logic [1:0]           press_event_t;
  typedef logic [REG_IDX_W-1:0] reg_index_t;

  // press event codes
  localparam press_event_t EV_NONE    = 2'd0;
  localparam press_event_t EV_SHORT   = 2'd1;
  localparam press_event_t EV_RELEASE = 2'd2;
  localparam press_event_t EV_LONG    = 2'd3;

  // register indexes
  localparam reg_index_t REG_ACTIVE_LEVEL = 4'd0;
  localparam reg_index_t REG_DEBOUNCE     = 4'd1;
  localparam reg_index_t REG_SHORT_PRESS  = 4'd2;
  localparam reg_index_t REG_LONG_PRESS   = 4'd3;

  // register reset values
  localparam logic     ACTIVE_LEVEL_RST = 1'b0;
  localparam setting_t DEBOUNCE_RST     = 16'd20;
  localparam setting_t SHORT_PRESS_RST  = 16'd1000;
  localparam setting_t LONG_PRESS_RST   = 16'd3000;

endpackage

[rtl/core/bdpc_if.sv]
// bdpc_if: valid/ready channels of the button debounce and press classifier
// one interface for the tick samples, one for the classified results
// depends on bdpc_pkg
`timescale 1ns / 1ps

interface bdpc_sample_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink (input valid, input raw_level, output ready);
endinterface

interface bdpc_result_if;
  logic                  valid;
  logic                  ready;
  logic                  clean_level;
  bdpc_pkg::press_event_t press_event;

  modport source (output valid, output clean_level, output press_event, input ready);
  modport sink (input valid, input clean_level, input press_event, output ready);
endinterface

[rtl/core/button_debounce_press_classifier.sv]
// Button debounce and press classifier. Each sample beat is one millisecond tick carrying
// the raw pin level; each tick yields exactly one result beat with the debounced level and
// a press event (none, short, release after a hold past short, long press). The block takes
// one tick per clock cycle: all counter and compare logic sits between the sample handshake
// and a single result register, so a result appears the cycle after its tick is taken, and
// a new tick is taken whenever the result register is empty or being drained. Writing the
// active level reinitializes the debounce and press state; other settings apply at once.
// Depends on bdpc_pkg and bdpc_if.
`timescale 1ns / 1ps

module button_debounce_press_classifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_en,
  input  bdpc_pkg::reg_index_t            reg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0] write_data,
  bdpc_sample_if.sink                     sample,
  bdpc_result_if.source                   result
);

  // compare width covers both the counters and the 16-bit settings
  localparam int CMP_W = (COUNT_WIDTH > bdpc_pkg::SETTING_W) ? COUNT_WIDTH : bdpc_pkg::SETTING_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // settings
  logic               active_level;
  bdpc_pkg::setting_t debounce_ticks;
  bdpc_pkg::setting_t short_press_ticks;
  bdpc_pkg::setting_t long_press_ticks;

  // tracking state; the previous debounced level always equals debounced_level between ticks
  logic                   sampled_level;
  logic                   debounced_level;
  logic                   settle_pending;
  logic                   press_armed;
  logic [COUNT_WIDTH-1:0] settle_count;
  logic [COUNT_WIDTH-1:0] press_count;

  // next values
  logic                   sampled_level_next;
  logic                   debounced_level_next;
  logic                   settle_pending_next;
  logic                   press_armed_next;
  logic [COUNT_WIDTH-1:0] settle_count_next;
  logic [COUNT_WIDTH-1:0] press_count_next;
  bdpc_pkg::press_event_t press_event_next;

  logic                   accept;
  logic                   raw_change;
  logic                   settle_hit;
  logic                   pending_mid;
  logic                   armed_mid;
  logic [COUNT_WIDTH-1:0] settle_inc;
  logic [COUNT_WIDTH-1:0] press_inc;

  // result register
  logic                   out_valid;
  logic                   out_clean_level;
  bdpc_pkg::press_event_t out_press_event;

  // handshake: take a tick when the result register is free or draining
  assign sample.ready = !out_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  assign result.valid       = out_valid;
  assign result.clean_level = out_clean_level;
  assign result.press_event = out_press_event;

  // one tick of debounce and press classification
  always_comb begin
    settle_inc = (settle_count == COUNT_MAX) ? COUNT_MAX : settle_count + 1'b1;
    press_inc  = (press_count == COUNT_MAX) ? COUNT_MAX : press_count + 1'b1;

    // raw change restarts the settle count
    raw_change         = sample.raw_level != sampled_level;
    sampled_level_next = sample.raw_level;
    settle_count_next  = raw_change ? '0 : settle_inc;
    pending_mid        = settle_pending || raw_change;

    // accept the sampled level once the count strictly exceeds the setting
    settle_hit = pending_mid &&
                 (CMP_W'(settle_count_next) > CMP_W'(debounce_ticks));
    debounced_level_next = settle_hit ? sample.raw_level : debounced_level;
    settle_pending_next  = pending_mid && !settle_hit;

    // press edge arms, release while armed classifies
    press_count_next = press_inc;
    armed_mid        = press_armed;
    press_event_next = bdpc_pkg::EV_NONE;
    if (debounced_level_next != debounced_level) begin
      if (debounced_level_next == active_level) begin
        press_count_next = '0;
        armed_mid        = 1'b1;
      end else if (press_armed) begin
        press_event_next = (CMP_W'(press_inc) <= CMP_W'(short_press_ticks)) ?
                           bdpc_pkg::EV_SHORT : bdpc_pkg::EV_RELEASE;
        armed_mid        = 1'b0;
      end
    end

    // long press fires once
    press_armed_next = armed_mid;
    if (armed_mid && (CMP_W'(press_count_next) >= CMP_W'(long_press_ticks))) begin
      press_event_next = bdpc_pkg::EV_LONG;
      press_armed_next = 1'b0;
    end
  end

  // settings and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_level      <= bdpc_pkg::ACTIVE_LEVEL_RST;
      debounce_ticks    <= bdpc_pkg::DEBOUNCE_RST;
      short_press_ticks <= bdpc_pkg::SHORT_PRESS_RST;
      long_press_ticks  <= bdpc_pkg::LONG_PRESS_RST;
      sampled_level     <= !bdpc_pkg::ACTIVE_LEVEL_RST;
      debounced_level   <= !bdpc_pkg::ACTIVE_LEVEL_RST;
      settle_pending    <= 1'b0;
      press_armed       <= 1'b0;
      settle_count      <= '0;
      press_count       <= '0;
    end else if (write_en) begin
      unique case (reg_index)
        bdpc_pkg::REG_ACTIVE_LEVEL: begin
          active_level    <= write_data[0];
          sampled_level   <= !write_data[0];
          debounced_level <= !write_data[0];
          settle_pending  <= 1'b0;
          press_armed     <= 1'b0;
          settle_count    <= '0;
          press_count     <= '0;
        end
        bdpc_pkg::REG_DEBOUNCE:    debounce_ticks    <= write_data;
        bdpc_pkg::REG_SHORT_PRESS: short_press_ticks <= write_data;
        bdpc_pkg::REG_LONG_PRESS:  long_press_ticks  <= write_data;
        default: ;
      endcase
    end else if (accept) begin
      sampled_level   <= sampled_level_next;
      debounced_level <= debounced_level_next;
      settle_pending  <= settle_pending_next;
      press_armed     <= press_armed_next;
      settle_count    <= settle_count_next;
      press_count     <= press_count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_clean_level <= debounced_level_next;
      out_press_event <= press_event_next;
    end
  end

`ifndef SYNTHESIS
  // a long press only comes from an armed press, armed before or on this tick
  assert property (@(posedge clk) disable iff (rst)
    (accept && !write_en && press_event_next == bdpc_pkg::EV_LONG) |-> armed_mid)
    else $error("long press without an armed press");

  // short press and release events only on a debounced release
  assert property (@(posedge clk) disable iff (rst)
    (accept && (press_event_next == bdpc_pkg::EV_SHORT ||
                press_event_next == bdpc_pkg::EV_RELEASE)) |->
    (debounced_level == active_level && debounced_level_next != active_level))
    else $error("release event without a debounced release");

  // a debounced change ends the settle wait
  assert property (@(posedge clk) disable iff (rst)
    (accept && !write_en && debounced_level_next != debounced_level) |=> !settle_pending)
    else $error("settle still pending after debounced change");

  // settle count saturates rather than wrapping
  assert property (@(posedge clk) disable iff (rst)
    (accept && !write_en && !raw_change && settle_count == COUNT_MAX) |=>
    (settle_count == COUNT_MAX))
    else $error("settle count wrapped");
`endif

endmodule
